// ===== hdl/srs_pkg.sv =====
// shared types, constants and codes for the servo pulse ramp selector
package srs_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int CH_W         = 2;
    localparam int PULSE_W      = 12;
    localparam int DELAY_W      = 10;
    localparam int DEB_W        = 8;
    localparam int VALUE_W      = 16;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int CFG_ADDR_W   = 3;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PULSE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SELECT = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHANNEL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BUSY        = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_PULSE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PULSE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_DELAY = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 3'd4;

    // reset values
    localparam logic [PULSE_W-1:0] PULSE_RESET      = 12'd1500;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RESET  = 12'd1000;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RESET  = 12'd2000;
    localparam logic [PULSE_W-1:0] STEP_RESET       = 12'd5;
    localparam logic [DELAY_W-1:0] STEP_DELAY_RESET = 10'd5;
    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET   = 8'd35;

    // angle mapping: x / 180 as (x * RECIP) >> RECIP_SHIFT, exact for x < 2^20
    localparam logic [7:0]  ANGLE_MAX   = 8'd180;
    localparam int          RECIP_SHIFT = 28;
    localparam logic [20:0] RECIP       = 21'd1491309;

    typedef struct packed {
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [PULSE_W-1:0] step;
        logic [DELAY_W-1:0] step_delay;
        logic [DEB_W-1:0]   debounce;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic                      button_level;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic                      button_level;
        logic [PULSE_W-1:0]        target;
    } prep_t;

    typedef struct packed {
        logic [CH_W-1:0]     active_channel;
        logic [PULSE_W-1:0]  pulse_us;
        logic                moving;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ===== hdl/srs_target.sv =====
// front pipeline: registers the command word and works out the clamped pulse target
module srs_target
    import srs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  up_valid,
    output logic  up_ready,
    input  cmd_t  up_cmd,
    output logic  dn_valid,
    input  logic  dn_ready,
    output prep_t dn_item
);

    logic v1_reg, v2_reg, v3_reg;
    logic take1, take2, take3;

    cmd_t              cmd1_reg;
    cmd_t              cmd2_reg;
    logic signed [21:0] prod_reg;
    logic signed [21:0] prod_next;
    prep_t             item3_reg;
    prep_t             item3_next;

    logic [7:0]         angle_c;
    logic signed [12:0] span;
    logic [19:0]        mag;
    logic [40:0]        recip_prod;
    logic [PULSE_W-1:0] quo;
    logic signed [16:0] want;
    logic signed [16:0] lo_s;
    logic signed [16:0] hi_s;

    assign take3    = !v3_reg || dn_ready;
    assign take2    = !v2_reg || take3;
    assign take1    = !v1_reg || take2;
    assign up_ready = take1;
    assign dn_valid = v3_reg;
    assign dn_item  = item3_reg;

    // stage 2: angle times span
    always_comb begin
        if (cmd1_reg.value < 16'sd0) begin
            angle_c = 8'd0;
        end else if (cmd1_reg.value > $signed({8'd0, ANGLE_MAX})) begin
            angle_c = ANGLE_MAX;
        end else begin
            angle_c = cmd1_reg.value[7:0];
        end
        span      = $signed({1'b0, cfg.max_pulse}) - $signed({1'b0, cfg.min_pulse});
        prod_next = $signed({1'b0, angle_c}) * 22'(span);
    end

    // stage 3: divide by 180, offset, clamp
    always_comb begin
        logic [21:0] abs_p;
        abs_p      = prod_reg[21] ? 22'(-prod_reg) : prod_reg;
        mag        = abs_p[19:0];
        recip_prod = {21'd0, mag} * {20'd0, RECIP};
        quo        = recip_prod[RECIP_SHIFT +: PULSE_W];
        lo_s       = $signed({5'd0, cfg.min_pulse});
        hi_s       = $signed({5'd0, cfg.max_pulse});
        if (cmd2_reg.kind == KIND_ANGLE) begin
            if (prod_reg[21]) begin
                want = lo_s - $signed({5'd0, quo});
            end else begin
                want = lo_s + $signed({5'd0, quo});
            end
        end else begin
            want = 17'(cmd2_reg.value);
        end
        item3_next.kind         = cmd2_reg.kind;
        item3_next.value        = cmd2_reg.value;
        item3_next.button_level = cmd2_reg.button_level;
        if (want < lo_s) begin
            item3_next.target = cfg.min_pulse;
        end else if (want > hi_s) begin
            item3_next.target = cfg.max_pulse;
        end else begin
            item3_next.target = want[PULSE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (take1) v1_reg <= up_valid;
            if (take2) v2_reg <= v1_reg;
            if (take3) v3_reg <= v2_reg;
        end
        if (take1 && up_valid) cmd1_reg <= up_cmd;
        if (take2 && v1_reg) begin
            cmd2_reg <= cmd1_reg;
            prod_reg <= prod_next;
        end
        if (take3 && v2_reg) item3_reg <= item3_next;
    end

endmodule

// ===== hdl/srs_core.sv =====
// channel state, ramp and button debounce update with the result register
module srs_core
    import srs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  prep_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic [PULSE_W-1:0] channel_pulse [NUM_CHANNELS];

    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [PULSE_W-1:0] active_pulse_reg, active_pulse_next;
    logic [PULSE_W-1:0] target_reg, target_next;
    logic               ramp_active_reg, ramp_active_next;
    logic               ramp_up_reg, ramp_up_next;
    logic [DELAY_W-1:0] step_wait_reg, step_wait_next;
    logic               last_btn_reg, last_btn_next;
    logic [DEB_W-1:0]   stable_reg, stable_next;
    logic               armed_reg, armed_next;
    logic               out_valid_reg;
    result_t            result_reg, result_next;

    logic               fire;
    logic               ch_load;
    logic               pulse_wr;
    logic [PULSE_W-1:0] pulse_new;
    logic [STATUS_W-1:0] status;
    logic [DELAY_W-1:0] delay_eff;
    logic [PULSE_W-1:0] step_eff;
    logic [DELAY_W-1:0] wait_inc;
    logic [PULSE_W:0]   up_sum;

    assign in_ready   = !out_valid_reg || out_ready;
    assign fire       = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    assign delay_eff = (cfg.step_delay == '0) ? DELAY_W'(1) : cfg.step_delay;
    assign step_eff  = (cfg.step == '0) ? PULSE_W'(1) : cfg.step;
    assign wait_inc  = step_wait_reg + DELAY_W'(1);
    assign up_sum    = {1'b0, active_pulse_reg} + {1'b0, step_eff};

    always_comb begin
        ch_next          = ch_reg;
        target_next      = target_reg;
        ramp_active_next = ramp_active_reg;
        ramp_up_next     = ramp_up_reg;
        step_wait_next   = step_wait_reg;
        last_btn_next    = last_btn_reg;
        stable_next      = stable_reg;
        armed_next       = armed_reg;
        ch_load          = 1'b0;
        pulse_wr         = 1'b0;
        pulse_new        = active_pulse_reg;
        status           = STATUS_OK;

        if (in_item.kind == KIND_TICK) begin
            if (ramp_active_reg) begin
                if (wait_inc < delay_eff) begin
                    step_wait_next = wait_inc;
                end else begin
                    step_wait_next = '0;
                    if (ramp_up_reg) begin
                        if (up_sum > {1'b0, target_reg}) begin
                            ramp_active_next = 1'b0;
                        end else begin
                            pulse_wr  = 1'b1;
                            pulse_new = up_sum[PULSE_W-1:0];
                        end
                    end else begin
                        if (active_pulse_reg < target_reg ||
                            (active_pulse_reg - target_reg) < step_eff) begin
                            ramp_active_next = 1'b0;
                        end else begin
                            pulse_wr  = 1'b1;
                            pulse_new = active_pulse_reg - step_eff;
                        end
                    end
                end
            end else begin
                if (in_item.button_level != last_btn_reg) begin
                    last_btn_next = in_item.button_level;
                    stable_next   = '0;
                end else if (stable_reg != {DEB_W{1'b1}}) begin
                    stable_next = stable_reg + DEB_W'(1);
                end
                if (stable_next > cfg.debounce) begin
                    if (armed_reg && !in_item.button_level) begin
                        armed_next = 1'b0;
                        ch_load    = 1'b1;
                        ch_next    = (ch_reg == CH_W'(NUM_CHANNELS - 1)) ? '0
                                                                      : ch_reg + CH_W'(1);
                    end
                    if (in_item.button_level) armed_next = 1'b1;
                end
            end
        end else if (ramp_active_reg) begin
            status = STATUS_BUSY;
        end else begin
            case (in_item.kind)
                KIND_PULSE, KIND_ANGLE: begin
                    if (in_item.target != active_pulse_reg) begin
                        target_next      = in_item.target;
                        ramp_up_next     = in_item.target > active_pulse_reg;
                        ramp_active_next = 1'b1;
                        step_wait_next   = '0;
                    end
                end
                KIND_SELECT: begin
                    if (in_item.value >= 16'sd1 &&
                        in_item.value <= $signed(VALUE_W'(NUM_CHANNELS))) begin
                        ch_load = 1'b1;
                        ch_next = CH_W'(in_item.value - 16'sd1);
                    end else begin
                        status = STATUS_BAD_CHANNEL;
                    end
                end
                default: begin
                    status = STATUS_OK;
                end
            endcase
        end

        // active pulse mirrors the selected channel's entry
        if (ch_load) begin
            active_pulse_next = channel_pulse[ch_next];
        end else begin
            active_pulse_next = pulse_new;
        end

        result_next.active_channel = ch_next;
        result_next.pulse_us       = active_pulse_next;
        result_next.moving         = ramp_active_next;
        result_next.status         = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                channel_pulse[i] <= PULSE_RESET;
            end
            ch_reg           <= '0;
            active_pulse_reg <= PULSE_RESET;
            target_reg       <= '0;
            ramp_active_reg  <= 1'b0;
            ramp_up_reg      <= 1'b0;
            step_wait_reg    <= '0;
            last_btn_reg     <= 1'b1;
            stable_reg       <= '0;
            armed_reg        <= 1'b1;
            out_valid_reg    <= 1'b0;
        end else begin
            if (in_ready) out_valid_reg <= in_valid;
            if (fire) begin
                if (pulse_wr) channel_pulse[ch_reg] <= pulse_new;
                ch_reg           <= ch_next;
                active_pulse_reg <= active_pulse_next;
                target_reg       <= target_next;
                ramp_active_reg  <= ramp_active_next;
                ramp_up_reg      <= ramp_up_next;
                step_wait_reg    <= step_wait_next;
                last_btn_reg     <= last_btn_next;
                stable_reg       <= stable_next;
                armed_reg        <= armed_next;
            end
        end
        if (fire) result_reg <= result_next;
    end

endmodule

// ===== hdl/servo_pulse_ramp_selector.sv =====
// top level of the three-channel servo tester: config registers and the two pipeline parts
//
// three-channel servo tester. each input word is a 1 ms tick, a set-pulse command, a
// set-angle command or a channel select, and each gives exactly one result word with the
// active channel, its pulse width, the ramp flag and a status. pulse and angle commands are
// clamped to min_pulse_us..max_pulse_us and, when the target differs from the pulse, start
// a ramp that moves by step_us every step_delay_ms ticks; while it runs, commands return
// busy and the button is ignored. on idle ticks a debounced button press steps to the next
// channel. one word is taken every clock cycle unless the m_ side stalls: three front
// stages form the clamped target (command register, angle multiply, divide-by-180 by
// reciprocal with offset and clamp), and one state stage updates the channel, ramp and
// debounce state into the output register, so this last stage's state update sets the
// one-word-per-cycle rate. backpressure on the m_ side stalls the pipeline stage by stage.
// write configuration only while no word is in flight.
module servo_pulse_ramp_selector
    import srs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [PULSE_W-1:0]    cfg_wdata,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // value[15:0], button_level[16], zero pad
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata    // active_channel[1:0], pulse_us[13:2],
                                             // moving[14], status[16:15], zero pad
);

    cfg_t    cfg_reg;
    cmd_t    in_cmd;
    prep_t   prep_item;
    logic    prep_valid;
    logic    prep_ready;
    result_t result;

    // configuration registers, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pulse  <= MIN_PULSE_RESET;
            cfg_reg.max_pulse  <= MAX_PULSE_RESET;
            cfg_reg.step       <= STEP_RESET;
            cfg_reg.step_delay <= STEP_DELAY_RESET;
            cfg_reg.debounce   <= DEBOUNCE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MIN_PULSE:  cfg_reg.min_pulse  <= cfg_wdata;
                REG_MAX_PULSE:  cfg_reg.max_pulse  <= cfg_wdata;
                REG_STEP:       cfg_reg.step       <= cfg_wdata;
                REG_STEP_DELAY: cfg_reg.step_delay <= cfg_wdata[DELAY_W-1:0];
                REG_DEBOUNCE:   cfg_reg.debounce   <= cfg_wdata[DEB_W-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // unpack the input word
    assign in_cmd.kind         = s_tuser;
    assign in_cmd.value        = s_tdata[VALUE_W-1:0];
    assign in_cmd.button_level = s_tdata[VALUE_W];

    // target front end
    srs_target u_target (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .up_valid (s_tvalid),
        .up_ready (s_tready),
        .up_cmd   (in_cmd),
        .dn_valid (prep_valid),
        .dn_ready (prep_ready),
        .dn_item  (prep_item)
    );

    // state update and result register
    srs_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (prep_valid),
        .in_ready   (prep_ready),
        .in_item    (prep_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // pack the result word, first field lowest
    assign m_tdata = {7'd0, result.status, result.moving, result.pulse_us,
                      result.active_channel};

endmodule
